// File: rtl/core/dfe_pkg.sv
// ----------------------------------------------------------------------------
// DMX512 frame engine package
// Shared types and constants for the slot engine front end, queue and back end.
// ----------------------------------------------------------------------------
package dfe_pkg;

	localparam int SLOT_IDX_W  = 10;
	localparam int BYTE_W      = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 10;
	localparam int MIN_SLOTS   = 24;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		MODE_WRITE    = 2'd0,
		MODE_READ     = 2'd1,
		MODE_TX_READY = 2'd2,
		MODE_RX_CHAR  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		PM_OFF = 2'd0,
		PM_TX  = 2'd1,
		PM_RX  = 2'd2
	} port_mode_t;

	typedef enum logic [1:0] {
		PH_BREAK = 2'd0,
		PH_START = 2'd1,
		PH_DATA  = 2'd2,
		PH_IDLE  = 2'd3
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PORT_MODE = 2'd0,
		REG_SLOTS     = 2'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MEM_NONE  = 2'd0,
		MEM_READ  = 2'd1,
		MEM_WRITE = 2'd2
	} mem_op_t;

	typedef struct packed {
		mem_op_t               op;
		logic [SLOT_IDX_W-1:0] addr;
		logic [BYTE_W-1:0]     wdata;
		logic                  rd_to_tx;
		logic                  tx_valid;
		logic                  tx_is_break;
		logic                  frame_done;
		logic [SLOT_IDX_W-1:0] frame_slots;
	} slot_op_t;

endpackage

// File: rtl/core/dfe_front.sv
// ----------------------------------------------------------------------------
// DMX512 frame engine front end
// Holds configuration and frame sequencing state, turns each transaction into
// a slot store operation plus result fields.
// ----------------------------------------------------------------------------
module dfe_front #(
	parameter int MAX_SLOTS = 512
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr,
	input  logic [dfe_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dfe_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             take,
	input  logic [1:0]                       mode,
	input  logic [dfe_pkg::SLOT_IDX_W-1:0]   slot_index,
	input  logic [dfe_pkg::BYTE_W-1:0]       slot_value,
	input  logic [dfe_pkg::BYTE_W-1:0]       rx_byte,
	input  logic                             rx_frame_error,
	output dfe_pkg::slot_op_t                op_entry
);

	localparam int CNT_W = $clog2(MAX_SLOTS + 2);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SLOTS);
	localparam logic [dfe_pkg::CFG_DATA_W-1:0] MAX_CFG = dfe_pkg::CFG_DATA_W'(MAX_SLOTS);
	localparam logic [dfe_pkg::CFG_DATA_W-1:0] MIN_CFG = dfe_pkg::CFG_DATA_W'(dfe_pkg::MIN_SLOTS);
	localparam logic [dfe_pkg::SLOT_IDX_W-1:0] MAX_IDX = dfe_pkg::SLOT_IDX_W'(MAX_SLOTS);

	dfe_pkg::phase_t     phase_q, phase_d;
	dfe_pkg::port_mode_t pmode_q;
	logic [CNT_W-1:0]    cnt_q, cnt_d, cnt_inc, rx_cnt_next;
	logic [CNT_W-1:0]    spf_q;
	logic                cnt_le_max;
	logic                idx_ok;
	dfe_pkg::mode_t      mode_in;
	logic [dfe_pkg::CFG_DATA_W-1:0] spf_clamped;

	assign mode_in     = dfe_pkg::mode_t'(mode);
	assign cnt_inc     = cnt_q + 1'b1;
	assign cnt_le_max  = (cnt_q <= MAX_CNT);
	assign rx_cnt_next = cnt_le_max ? cnt_inc : cnt_q;
	assign idx_ok      = (slot_index <= MAX_IDX);

	always_comb begin
		if (cfg_data < MIN_CFG) begin
			spf_clamped = MIN_CFG;
		end else if (cfg_data > MAX_CFG) begin
			spf_clamped = MAX_CFG;
		end else begin
			spf_clamped = cfg_data;
		end
	end

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		if (take) begin
			case (mode_in)
				dfe_pkg::MODE_TX_READY: begin
					if (pmode_q == dfe_pkg::PM_TX) begin
						case (phase_q)
							dfe_pkg::PH_START: begin
								cnt_d   = CNT_W'(1);
								phase_d = dfe_pkg::PH_DATA;
							end
							dfe_pkg::PH_DATA: begin
								if (cnt_le_max) begin
									cnt_d = cnt_inc;
									if (cnt_inc > spf_q) begin
										phase_d = dfe_pkg::PH_BREAK;
									end
								end else begin
									phase_d = dfe_pkg::PH_START;
								end
							end
							default: begin
								phase_d = dfe_pkg::PH_START;
							end
						endcase
					end
				end
				dfe_pkg::MODE_RX_CHAR: begin
					if (pmode_q == dfe_pkg::PM_RX) begin
						if (rx_frame_error) begin
							phase_d = dfe_pkg::PH_BREAK;
							cnt_d   = '0;
						end else begin
							case (phase_q)
								dfe_pkg::PH_BREAK: begin
									if (rx_byte == '0) begin
										phase_d = dfe_pkg::PH_DATA;
										cnt_d   = CNT_W'(1);
									end else begin
										phase_d = dfe_pkg::PH_IDLE;
									end
								end
								dfe_pkg::PH_DATA: begin
									cnt_d = rx_cnt_next;
									if (rx_cnt_next > MAX_CNT) begin
										phase_d = dfe_pkg::PH_IDLE;
									end
								end
								default: begin
									phase_d = phase_q;
								end
							endcase
						end
					end
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
	end

	always_comb begin
		op_entry = '0;
		op_entry.op = dfe_pkg::MEM_NONE;
		case (mode_in)
			dfe_pkg::MODE_WRITE: begin
				if (idx_ok) begin
					op_entry.op    = dfe_pkg::MEM_WRITE;
					op_entry.addr  = slot_index;
					op_entry.wdata = slot_value;
				end
			end
			dfe_pkg::MODE_READ: begin
				if (idx_ok) begin
					op_entry.op   = dfe_pkg::MEM_READ;
					op_entry.addr = slot_index;
				end
			end
			dfe_pkg::MODE_TX_READY: begin
				if (pmode_q == dfe_pkg::PM_TX) begin
					op_entry.tx_valid = 1'b1;
					if (phase_q == dfe_pkg::PH_START) begin
						op_entry.op       = dfe_pkg::MEM_READ;
						op_entry.rd_to_tx = 1'b1;
					end else if (phase_q == dfe_pkg::PH_DATA && cnt_le_max) begin
						op_entry.op       = dfe_pkg::MEM_READ;
						op_entry.addr     = dfe_pkg::SLOT_IDX_W'(cnt_q);
						op_entry.rd_to_tx = 1'b1;
					end else begin
						op_entry.tx_is_break = 1'b1;
					end
				end
			end
			dfe_pkg::MODE_RX_CHAR: begin
				if (pmode_q == dfe_pkg::PM_RX) begin
					if (rx_frame_error) begin
						if (cnt_q != '0) begin
							op_entry.frame_done  = 1'b1;
							op_entry.frame_slots = dfe_pkg::SLOT_IDX_W'(cnt_q);
						end
					end else if (phase_q == dfe_pkg::PH_DATA && cnt_le_max) begin
						op_entry.op    = dfe_pkg::MEM_WRITE;
						op_entry.addr  = dfe_pkg::SLOT_IDX_W'(cnt_q);
						op_entry.wdata = rx_byte;
					end
				end
			end
			default: begin
				op_entry.op = dfe_pkg::MEM_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dfe_pkg::PH_IDLE;
			cnt_q   <= '0;
			pmode_q <= dfe_pkg::PM_OFF;
			spf_q   <= MAX_CNT;
		end else if (cfg_wr) begin
			case (dfe_pkg::cfg_reg_t'(cfg_index))
				dfe_pkg::REG_PORT_MODE: begin
					cnt_q <= '0;
					if (cfg_data[1:0] == dfe_pkg::PM_TX) begin
						pmode_q <= dfe_pkg::PM_TX;
						phase_q <= dfe_pkg::PH_BREAK;
					end else if (cfg_data[1:0] == dfe_pkg::PM_RX) begin
						pmode_q <= dfe_pkg::PM_RX;
						phase_q <= dfe_pkg::PH_IDLE;
					end else begin
						pmode_q <= dfe_pkg::PM_OFF;
						phase_q <= dfe_pkg::PH_IDLE;
					end
				end
				dfe_pkg::REG_SLOTS: begin
					spf_q <= CNT_W'(spf_clamped);
				end
				default: begin
					spf_q <= spf_q;
				end
			endcase
		end else begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

// File: rtl/core/dfe_queue.sv
// ----------------------------------------------------------------------------
// DMX512 frame engine operation queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module dfe_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dfe_pkg::slot_op_t push_entry,
	input  logic              pop,
	output dfe_pkg::slot_op_t head,
	output logic              head_valid,
	output logic              full
);

	localparam int PTR_W = $clog2(dfe_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(dfe_pkg::QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(dfe_pkg::QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(dfe_pkg::QUEUE_DEPTH - 1);

	dfe_pkg::slot_op_t entry_q [dfe_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign head       = entry_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign full       = (count_q == DEPTH_CNT);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/dfe_back.sv
// ----------------------------------------------------------------------------
// DMX512 frame engine back end
// Owns the slot store: clears it after reset, executes queued operations and
// drives the registered result transaction.
// ----------------------------------------------------------------------------
module dfe_back #(
	parameter int MAX_SLOTS = 512
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dfe_pkg::slot_op_t              head,
	input  logic                           head_valid,
	output logic                           pop,
	output logic                           clear_busy,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [dfe_pkg::BYTE_W-1:0]     read_value,
	output logic                           tx_valid,
	output logic [dfe_pkg::BYTE_W-1:0]     tx_byte,
	output logic                           tx_is_break,
	output logic                           frame_done,
	output logic [dfe_pkg::SLOT_IDX_W-1:0] frame_slots
);

	localparam int DEPTH = MAX_SLOTS + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_SLOTS);

	logic [dfe_pkg::BYTE_W-1:0] mem [DEPTH];
	logic                       clear_q;
	logic [AW-1:0]              clr_addr_q;
	logic                       v_s1;
	dfe_pkg::slot_op_t          ent_s1;
	logic [dfe_pkg::BYTE_W-1:0] rdata_s1;
	logic                       out_free, s1_adv;
	logic [AW-1:0]              op_addr;

	assign out_free   = !out_valid || !out_stall;
	assign s1_adv     = !v_s1 || out_free;
	assign pop        = head_valid && s1_adv && !clear_q;
	assign clear_busy = clear_q;
	assign op_addr    = head.addr[AW-1:0];

	always_ff @(posedge clk) begin
		if (clear_q) begin
			mem[clr_addr_q] <= '0;
		end else if (pop && head.op == dfe_pkg::MEM_WRITE) begin
			mem[op_addr] <= head.wdata;
		end
		if (pop && head.op == dfe_pkg::MEM_READ) begin
			rdata_s1 <= mem[op_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q    <= 1'b1;
			clr_addr_q <= '0;
		end else if (clear_q) begin
			if (clr_addr_q == LAST_ADDR) begin
				clear_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_s1 <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (s1_adv) begin
				v_s1 <= pop;
			end
			if (out_free) begin
				out_valid <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && v_s1) begin
			read_value  <= (ent_s1.op == dfe_pkg::MEM_READ && !ent_s1.rd_to_tx) ? rdata_s1 : '0;
			tx_byte     <= (ent_s1.op == dfe_pkg::MEM_READ && ent_s1.rd_to_tx) ? rdata_s1 : '0;
			tx_valid    <= ent_s1.tx_valid;
			tx_is_break <= ent_s1.tx_is_break;
			frame_done  <= ent_s1.frame_done;
			frame_slots <= ent_s1.frame_slots;
		end
	end

endmodule

// File: rtl/core/dmx512_frame_engine.sv
// ----------------------------------------------------------------------------
// DMX512 frame engine
// Slot store with host access, frame transmitter and frame receiver.
// ----------------------------------------------------------------------------
// Each transaction (host slot write or read, transmitter ready, received
// character) yields exactly one result transaction. The engine takes one
// transaction per cycle while in_stall is low; the single port of the slot
// store sets that figure, each transaction using it at most once. A result
// is registered in the queue, the back end stage and the output register,
// and a four-entry queue between sequencing and the slot store absorbs
// output stalls. After reset the MAX_SLOTS + 1 slots (513 at the default)
// are cleared one slot per cycle; in_stall stays high during that pass,
// while configuration writes are taken as usual. cfg_ready is always high.
module dmx512_frame_engine #(
	parameter int MAX_SLOTS = 512
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [dfe_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dfe_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       mode,
	input  logic [dfe_pkg::SLOT_IDX_W-1:0]   slot_index,
	input  logic [dfe_pkg::BYTE_W-1:0]       slot_value,
	input  logic [dfe_pkg::BYTE_W-1:0]       rx_byte,
	input  logic                             rx_frame_error,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [dfe_pkg::BYTE_W-1:0]       read_value,
	output logic                             tx_valid,
	output logic [dfe_pkg::BYTE_W-1:0]       tx_byte,
	output logic                             tx_is_break,
	output logic                             frame_done,
	output logic [dfe_pkg::SLOT_IDX_W-1:0]   frame_slots
);

	logic              take, q_full, q_valid, pop, clear_busy;
	dfe_pkg::slot_op_t push_entry, head;

	assign cfg_ready = 1'b1;
	assign in_stall  = clear_busy || q_full;
	assign take      = in_valid && !in_stall;

	dfe_front #(
		.MAX_SLOTS(MAX_SLOTS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.take           (take),
		.mode           (mode),
		.slot_index     (slot_index),
		.slot_value     (slot_value),
		.rx_byte        (rx_byte),
		.rx_frame_error (rx_frame_error),
		.op_entry       (push_entry)
	);

	dfe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (take),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.head_valid (q_valid),
		.full       (q_full)
	);

	dfe_back #(
		.MAX_SLOTS(MAX_SLOTS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_valid  (q_valid),
		.pop         (pop),
		.clear_busy  (clear_busy),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.read_value  (read_value),
		.tx_valid    (tx_valid),
		.tx_byte     (tx_byte),
		.tx_is_break (tx_is_break),
		.frame_done  (frame_done),
		.frame_slots (frame_slots)
	);

endmodule

// File: rtl/core/dfe_checker.sv
// ----------------------------------------------------------------------------
// DMX512 frame engine port checker
// Concurrent checks on the result transactions seen at the top-level ports.
// ----------------------------------------------------------------------------
module dfe_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [dfe_pkg::BYTE_W-1:0]       read_value,
	input logic                             tx_valid,
	input logic [dfe_pkg::BYTE_W-1:0]       tx_byte,
	input logic                             tx_is_break,
	input logic                             frame_done,
	input logic [dfe_pkg::SLOT_IDX_W-1:0]   frame_slots
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_value) && $stable(tx_byte)
			&& $stable(tx_valid) && $stable(frame_slots))
		else $error("result changed while stalled");

	a_break_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tx_is_break |-> tx_valid && tx_byte == '0)
		else $error("break result without zero character");

	a_no_tx_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !tx_valid |-> tx_byte == '0 && !tx_is_break)
		else $error("character fields set without transmit");

	a_frame_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame_done == (frame_slots != '0)))
		else $error("frame count disagrees with frame done");

	a_read_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_value != '0 |-> !tx_valid && !frame_done)
		else $error("read data mixed with another result");

endmodule

bind dmx512_frame_engine dfe_checker u_dfe_checker (.*);

// File: dv/dmx512_frame_engine_test.sv
// ----------------------------------------------------------------------------
// DMX512 frame engine testbench
// Drives host slot accesses, transmitter-ready events and received characters
// into the engine under varying port mode and slot count settings, checks
// each result field by field against a cycle-free model of the slot engine
// or, for typed directed rows, the table. Covers a directed table, random
// bursts of well-formed frames mixed with noise, a slot count lowered in the
// middle of an output frame and a long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module dmx512_frame_engine_test;

	localparam int                SLOT_MAX    = 512;
	localparam int                CYCLE_LIMIT = 200000;
	localparam int                HOLD_CYCLES = 300;
	localparam int                EPOCH_ITEMS = 130;
	localparam logic [1:0]        PM_RESERVED = 2'd3;

	localparam int BYTE_W     = dfe_pkg::BYTE_W;
	localparam int SLOT_IDX_W = dfe_pkg::SLOT_IDX_W;
	localparam int CFG_IDX_W  = dfe_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = dfe_pkg::CFG_DATA_W;
	localparam int MIN_SLOTS  = dfe_pkg::MIN_SLOTS;

	localparam dfe_pkg::mode_t    M_WR  = dfe_pkg::MODE_WRITE;
	localparam dfe_pkg::mode_t    M_RD  = dfe_pkg::MODE_READ;
	localparam dfe_pkg::mode_t    M_TX  = dfe_pkg::MODE_TX_READY;
	localparam dfe_pkg::mode_t    M_RX  = dfe_pkg::MODE_RX_CHAR;
	localparam dfe_pkg::cfg_reg_t R_PM  = dfe_pkg::REG_PORT_MODE;
	localparam dfe_pkg::cfg_reg_t R_SPF = dfe_pkg::REG_SLOTS;

	typedef struct packed {
		logic [BYTE_W-1:0]     read_value;
		logic                  tx_valid;
		logic [BYTE_W-1:0]     tx_byte;
		logic                  tx_is_break;
		logic                  frame_done;
		logic [SLOT_IDX_W-1:0] frame_slots;
	} dmx_result_t;

	typedef struct {
		dfe_pkg::mode_t        mode;
		logic [SLOT_IDX_W-1:0] idx;
		logic [BYTE_W-1:0]     val;
		logic [BYTE_W-1:0]     rxb;
		logic                  ferr;
	} dmx_event_t;

	typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		dfe_pkg::mode_t        mode;
		dfe_pkg::cfg_reg_t     sel;
		logic [SLOT_IDX_W-1:0] idx;
		logic [BYTE_W-1:0]     val;
		logic [BYTE_W-1:0]     rxb;
		logic                  ferr;
		bit                    typed;
		dmx_result_t           want;
	} stim_row_t;

	localparam dmx_result_t ZERO_RESULT = '0;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [1:0]            mode = '0;
	logic [SLOT_IDX_W-1:0] slot_index = '0;
	logic [BYTE_W-1:0]     slot_value = '0;
	logic [BYTE_W-1:0]     rx_byte = '0;
	logic                  rx_frame_error = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [BYTE_W-1:0]     read_value;
	logic                  tx_valid;
	logic [BYTE_W-1:0]     tx_byte;
	logic                  tx_is_break;
	logic                  frame_done;
	logic [SLOT_IDX_W-1:0] frame_slots;

	dmx512_frame_engine #(.MAX_SLOTS(SLOT_MAX)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.slot_index    (slot_index),
		.slot_value    (slot_value),
		.rx_byte       (rx_byte),
		.rx_frame_error(rx_frame_error),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.read_value    (read_value),
		.tx_valid      (tx_valid),
		.tx_byte       (tx_byte),
		.tx_is_break   (tx_is_break),
		.frame_done    (frame_done),
		.frame_slots   (frame_slots)
	);

	// model state
	logic [BYTE_W-1:0]     slot_image [0:SLOT_MAX];
	dfe_pkg::phase_t       model_phase = dfe_pkg::PH_IDLE;
	logic [SLOT_IDX_W-1:0] model_count = '0;
	dfe_pkg::port_mode_t   model_port = dfe_pkg::PM_OFF;
	logic [SLOT_IDX_W-1:0] model_slots = SLOT_IDX_W'(SLOT_MAX);

	dmx_result_t pending_outputs [$];
	stim_row_t   dir_rows [$];

	int fail_count = 0;
	int items_sent = 0;
	int cycle_count = 0;
	int send_idle_pct = 24;
	int rcv_idle_pct = 85;
	int hold_reqs = 0;
	int hold_served = 0;
	int hold_left = 0;
	int rx_stage = 0;
	int rx_left = 0;
	int tx_chars_seen = 0;
	int breaks_seen = 0;
	int frames_seen = 0;
	int slot_picks [9] = '{0, 23, 24, 25, 200, 511, 512, 513, 1023};

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// output stall: long hold-off on request, random idling otherwise
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_reqs) begin
			out_stall   <= 1'b1;
			hold_served <= hold_served + 1;
			hold_left   <= HOLD_CYCLES;
		end else begin
			out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
		end
	end

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		dmx_result_t got;
		dmx_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{read_value, tx_valid, tx_byte, tx_is_break, frame_done, frame_slots};
			if (got.tx_valid) tx_chars_seen++;
			if (got.tx_is_break) breaks_seen++;
			if (got.frame_done) frames_seen++;
			if (pending_outputs.size() == 0) begin
				$display("%0t: unexpected result transaction, expected none actual %p",
					$time, got);
				fail_count++;
			end else begin
				want = pending_outputs.pop_front();
				check_field("read_value", want.read_value, got.read_value);
				check_field("tx_valid", want.tx_valid, got.tx_valid);
				check_field("tx_byte", want.tx_byte, got.tx_byte);
				check_field("tx_is_break", want.tx_is_break, got.tx_is_break);
				check_field("frame_done", want.frame_done, got.frame_done);
				check_field("frame_slots", want.frame_slots, got.frame_slots);
			end
		end
	end

	function automatic void apply_config(dfe_pkg::cfg_reg_t sel, logic [CFG_DATA_W-1:0] data);
		if (sel == R_PM) begin
			model_port  = (data[1:0] == PM_RESERVED) ? dfe_pkg::PM_OFF
				: dfe_pkg::port_mode_t'(data[1:0]);
			model_phase = (model_port == dfe_pkg::PM_TX) ? dfe_pkg::PH_BREAK
				: dfe_pkg::PH_IDLE;
			model_count = '0;
		end else if (sel == R_SPF) begin
			if (data < MIN_SLOTS)
				model_slots = SLOT_IDX_W'(MIN_SLOTS);
			else if (data > SLOT_MAX)
				model_slots = SLOT_IDX_W'(SLOT_MAX);
			else
				model_slots = data;
		end
	endfunction

	function automatic dmx_result_t slot_engine_step(dmx_event_t ev);
		dmx_result_t o;
		o = '0;
		case (ev.mode)
			M_WR: begin
				if (ev.idx <= SLOT_MAX) slot_image[ev.idx] = ev.val;
			end
			M_RD: begin
				if (ev.idx <= SLOT_MAX) o.read_value = slot_image[ev.idx];
			end
			M_TX: begin
				if (model_port == dfe_pkg::PM_TX) begin
					o.tx_valid = 1'b1;
					if (model_phase == dfe_pkg::PH_START) begin
						o.tx_byte   = slot_image[0];
						model_count = SLOT_IDX_W'(1);
						model_phase = dfe_pkg::PH_DATA;
					end else if (model_phase == dfe_pkg::PH_DATA
							&& model_count <= SLOT_MAX) begin
						o.tx_byte   = slot_image[model_count];
						model_count = model_count + 1'b1;
						if (model_count > model_slots) model_phase = dfe_pkg::PH_BREAK;
					end else begin
						o.tx_is_break = 1'b1;
						model_phase   = dfe_pkg::PH_START;
					end
				end
			end
			M_RX: begin
				if (model_port == dfe_pkg::PM_RX) begin
					if (ev.ferr) begin
						model_phase = dfe_pkg::PH_BREAK;
						if (model_count != 0) begin
							o.frame_done  = 1'b1;
							o.frame_slots = model_count;
						end
						model_count = '0;
					end else if (model_phase == dfe_pkg::PH_BREAK) begin
						if (ev.rxb == 8'h00) begin
							model_phase = dfe_pkg::PH_DATA;
							model_count = SLOT_IDX_W'(1);
						end else begin
							model_phase = dfe_pkg::PH_IDLE;
						end
					end else if (model_phase == dfe_pkg::PH_DATA) begin
						if (model_count <= SLOT_MAX) begin
							slot_image[model_count] = ev.rxb;
							model_count = model_count + 1'b1;
						end
						if (model_count > SLOT_MAX) model_phase = dfe_pkg::PH_IDLE;
					end
				end
			end
			default: begin
				o = '0;
			end
		endcase
		return o;
	endfunction

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_outputs.size() != 0) @(posedge clk);
	endtask

	task automatic write_cfg(dfe_pkg::cfg_reg_t sel, logic [CFG_DATA_W-1:0] data);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		apply_config(sel, data);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_item(dmx_event_t ev, bit typed, dmx_result_t want);
		dmx_result_t pred;
		if (send_idle_pct != 0) begin
			while ($urandom_range(0, 99) < send_idle_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid       <= 1'b1;
		mode           <= ev.mode;
		slot_index     <= ev.idx;
		slot_value     <= ev.val;
		rx_byte        <= ev.rxb;
		rx_frame_error <= ev.ferr;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pred = slot_engine_step(ev);
		pending_outputs.push_back(typed ? want : pred);
		items_sent++;
	endtask

	function automatic dmx_event_t noise_event();
		dmx_event_t ev;
		ev.mode = dfe_pkg::mode_t'($urandom_range(0, 3));
		if ($urandom_range(0, 4) == 0)
			ev.idx = SLOT_IDX_W'($urandom_range(0, 1023));
		else
			ev.idx = SLOT_IDX_W'($urandom_range(0, SLOT_MAX));
		ev.val  = 8'($urandom);
		ev.rxb  = 8'($urandom);
		ev.ferr = 1'($urandom_range(0, 1));
		return ev;
	endfunction

	// mostly well-formed receive frames: break, start code, up to 30 data slots
	function automatic dmx_event_t frame_event();
		dmx_event_t ev;
		ev = noise_event();
		ev.mode = M_RX;
		ev.ferr = 1'b0;
		if (rx_stage == 0 || (rx_stage == 2 && rx_left == 0)) begin
			ev.ferr  = 1'b1;
			rx_stage = 1;
		end else if (rx_stage == 1) begin
			if ($urandom_range(0, 6) != 0) ev.rxb = 8'h00;
			rx_stage = 2;
			rx_left  = $urandom_range(0, 30);
		end else begin
			rx_left--;
		end
		return ev;
	endfunction

	task automatic run_burst(int n);
		dmx_event_t ev;
		int k;
		int pick;
		for (k = 0; k < n; k++) begin
			ev   = noise_event();
			pick = $urandom_range(0, 99);
			if (model_port == dfe_pkg::PM_TX) begin
				if (pick < 70) begin
					ev.mode = M_TX;
				end else if (pick < 85) begin
					ev.mode = M_WR;
					ev.idx  = SLOT_IDX_W'($urandom_range(0, 40));
				end
			end else if (model_port == dfe_pkg::PM_RX) begin
				if (pick < 75) begin
					ev = frame_event();
				end else if (pick < 88) begin
					ev.mode = M_RD;
					ev.idx  = SLOT_IDX_W'($urandom_range(0, 40));
				end
			end
			send_item(ev, 1'b0, ZERO_RESULT);
		end
	endtask

	task automatic random_epoch();
		int pick;
		logic [1:0] pm_code;
		logic [CFG_DATA_W-1:0] data;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < 70) begin
			if (pick < 40)      pm_code = dfe_pkg::PM_TX;
			else if (pick < 80) pm_code = dfe_pkg::PM_RX;
			else if (pick < 90) pm_code = dfe_pkg::PM_OFF;
			else                pm_code = PM_RESERVED;
			data = {8'h00, pm_code};
			if ($urandom_range(0, 3) == 0) data[CFG_DATA_W-1:2] = 8'($urandom);
			write_cfg(R_PM, data);
		end
		if ($urandom_range(0, 99) < 60) begin
			if ($urandom_range(0, 2) == 0)
				data = CFG_DATA_W'($urandom_range(0, 1023));
			else
				data = CFG_DATA_W'(slot_picks[$urandom_range(0, 8)]);
			write_cfg(R_SPF, data);
		end
		run_burst($urandom_range(15, 45));
	endtask

	initial begin
		stim_row_t row;
		dmx_event_t ev;
		int k;
		int prof;
		int budget;

		arst_n <= 1'b0;
		foreach (slot_image[i]) slot_image[i] = '0;

		dir_rows = '{
			'{ROW_ITEM, M_RD, R_PM,    0,   0,   0, 0, 1, ZERO_RESULT},
			'{ROW_ITEM, M_RD, R_PM,  512,   0,   0, 0, 1, ZERO_RESULT},
			'{ROW_ITEM, M_WR, R_PM,  512, 255,   0, 0, 1, ZERO_RESULT},
			'{ROW_ITEM, M_RD, R_PM,  512,   0,   0, 0, 1, '{255, 0, 0, 0, 0, 0}},
			'{ROW_ITEM, M_WR, R_PM,  513, 170,   0, 0, 1, ZERO_RESULT},
			'{ROW_ITEM, M_RD, R_PM,  513,   0,   0, 0, 1, ZERO_RESULT},
			'{ROW_ITEM, M_RD, R_PM, 1023,   0,   0, 0, 1, ZERO_RESULT},
			'{ROW_ITEM, M_TX, R_PM,    0,   0,   0, 0, 1, ZERO_RESULT},
			'{ROW_ITEM, M_RX, R_PM,    0,   0, 255, 1, 1, ZERO_RESULT},
			'{ROW_ITEM, M_WR, R_PM,    1,  90,   0, 0, 1, ZERO_RESULT},
			'{ROW_CFG,  M_WR, R_SPF,   0,   0,   0, 0, 0, ZERO_RESULT},
			'{ROW_CFG,  M_WR, R_PM,    1,   0,   0, 0, 0, ZERO_RESULT},
			'{ROW_ITEM, M_TX, R_PM,    0,   0,   0, 0, 1, '{0, 1, 0, 1, 0, 0}},
			'{ROW_ITEM, M_TX, R_PM,    0,   0,   0, 0, 1, '{0, 1, 0, 0, 0, 0}},
			'{ROW_ITEM, M_TX, R_PM,    0,   0,   0, 0, 1, '{0, 1, 90, 0, 0, 0}},
			'{ROW_ITEM, M_TX, R_PM,    0,   0,   0, 0, 0, ZERO_RESULT},
			'{ROW_ITEM, M_RX, R_PM,    0,   0,   1, 0, 1, ZERO_RESULT},
			'{ROW_CFG,  M_WR, R_PM,    3,   0,   0, 0, 0, ZERO_RESULT},
			'{ROW_ITEM, M_TX, R_PM,    0,   0,   0, 0, 1, ZERO_RESULT},
			'{ROW_CFG,  M_WR, R_SPF, 1023,  0,   0, 0, 0, ZERO_RESULT},
			'{ROW_CFG,  M_WR, R_PM,    2,   0,   0, 0, 0, ZERO_RESULT},
			'{ROW_ITEM, M_RX, R_PM,    0,   0, 119, 0, 1, ZERO_RESULT},
			'{ROW_ITEM, M_RX, R_PM,    0,   0, 255, 1, 1, ZERO_RESULT},
			'{ROW_ITEM, M_RX, R_PM,    0,   0,   0, 0, 1, ZERO_RESULT},
			'{ROW_ITEM, M_RX, R_PM,    0,   0,  17, 0, 1, ZERO_RESULT},
			'{ROW_ITEM, M_RX, R_PM,    0,   0, 255, 0, 1, ZERO_RESULT},
			'{ROW_ITEM, M_RX, R_PM,    0,   0,   0, 1, 1, '{0, 0, 0, 0, 1, 3}},
			'{ROW_ITEM, M_RD, R_PM,    2,   0,   0, 0, 1, '{255, 0, 0, 0, 0, 0}},
			'{ROW_ITEM, M_RX, R_PM,    0,   0,  85, 0, 0, ZERO_RESULT},
			'{ROW_ITEM, M_TX, R_PM,    0,   0,   0, 0, 1, ZERO_RESULT},
			'{ROW_ITEM, M_RX, R_PM,    0,   0,  51, 1, 0, ZERO_RESULT}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.kind == ROW_CFG) begin
				write_cfg(row.sel, row.idx);
			end else begin
				ev.mode = row.mode;
				ev.idx  = row.idx;
				ev.val  = row.val;
				ev.rxb  = row.rxb;
				ev.ferr = row.ferr;
				send_item(ev, row.typed, row.want);
			end
		end

		for (prof = 0; prof < 3; prof++) begin
			case (prof)
				0: begin
					send_idle_pct = 24;
					rcv_idle_pct  = 85;
				end
				1: begin
					send_idle_pct = 85;
					rcv_idle_pct  = 24;
				end
				default: begin
					send_idle_pct = 0;
					rcv_idle_pct  = 0;
				end
			endcase
			budget = items_sent + EPOCH_ITEMS;
			while (items_sent < budget) random_epoch();
		end

		// short output frames while the result side holds off
		write_cfg(R_SPF, CFG_DATA_W'(MIN_SLOTS));
		write_cfg(R_PM, CFG_DATA_W'(dfe_pkg::PM_TX));
		hold_reqs++;
		for (k = 0; k < 40; k++) begin
			ev = noise_event();
			ev.mode = (k % 8 == 7) ? M_WR : M_TX;
			send_item(ev, 1'b0, ZERO_RESULT);
		end

		// lower the slot count in the middle of a frame
		write_cfg(R_SPF, CFG_DATA_W'(SLOT_MAX));
		write_cfg(R_PM, CFG_DATA_W'(dfe_pkg::PM_TX));
		for (k = 0; k < 40; k++) begin
			ev = noise_event();
			ev.mode = M_TX;
			send_item(ev, 1'b0, ZERO_RESULT);
		end
		write_cfg(R_SPF, CFG_DATA_W'(30));
		for (k = 0; k < 6; k++) begin
			ev = noise_event();
			ev.mode = M_TX;
			send_item(ev, 1'b0, ZERO_RESULT);
		end

		wait_idle();
		repeat (16) @(posedge clk);

		$display("Run covered %0d transactions, %0d characters sent, %0d breaks,",
			items_sent, tx_chars_seen, breaks_seen);
		$display("%0d received frames reported, across three idling profiles.", frames_seen);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches found", fail_count);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// File: dmx512_frame_engine.f
rtl/core/dfe_pkg.sv
rtl/core/dfe_front.sv
rtl/core/dfe_queue.sv
rtl/core/dfe_back.sv
rtl/core/dmx512_frame_engine.sv
rtl/core/dfe_checker.sv
dv/dmx512_frame_engine_test.sv
